>>> sv/lsfs_pkg.sv
package lsfs_pkg;

	// Item kinds carried on the input tuser lane.
	typedef enum logic [1:0] {
		MODE_WRITE = 2'd0,
		MODE_SWAP  = 2'd1,
		MODE_TICK  = 2'd2,
		MODE_NONE  = 2'd3
	} mode_t;

	// Fixed field widths of the stream and configuration ports.
	localparam int unsigned MODE_W  = 2;
	localparam int unsigned ADDR_W  = 11;
	localparam int unsigned VALUE_W = 8;
	localparam int unsigned LEDCT_W = 10;
	localparam int unsigned IN_DW   = 24;
	localparam int unsigned OUT_DW  = 8;

	// Latch byte counter holds up to 3 * ceil(1023 / 64).
	localparam int unsigned LATCH_W = 6;

	// Requested led_count after reset, before clamping.
	localparam int unsigned LEDCT_RST = 320;

	// Pixel bytes always go out with the top bit set.
	localparam logic [VALUE_W-1:0] PIXEL_MARK = 8'h80;

endpackage

>>> sv/lsfs_ram.sv
module lsfs_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 3072
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> sv/led_strip_frame_serializer_unit.sv
// Each accepted input beat passes through stage one, with the frame RAM read, and then the result register.
// Throughput: one input beat per cycle while the output is not stalled, set by the state
// update and the registered frame RAM read port; with both stages full an output stall stops input.
// Reset: arst_n clears control state; led_count returns to 320 (clamped to MAX_LEDS),
// the serializer starts with the latch zeros, and the frame RAM holds no defined data.
module led_strip_frame_serializer_unit
	import lsfs_pkg::*;
#(
	parameter int unsigned MAX_LEDS = 512
) (
	input  logic                clk,
	input  logic                arst_n,
	// Input stream.
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [IN_DW-1:0]    s_tdata,   // [10:0] byte_address, [18:11] byte_value, zero pad
	input  logic [MODE_W-1:0]   s_tuser,   // [1:0] mode
	// Output stream.
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [OUT_DW-1:0]   m_tdata,   // [0] clock_pulse, [1] data_bit, zero pad
	output logic [0:0]          m_tuser,   // [0] in_latch
	output logic                m_tlast,   // frame_end
	// Configuration write channel.
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [LEDCT_W-1:0]  cfg_data   // led_count
);

	localparam int unsigned HALF      = MAX_LEDS * 3;
	localparam int unsigned DEPTH     = 2 * HALF;
	localparam int unsigned AW        = $clog2(DEPTH);
	localparam int unsigned IDX_W     = (HALF > 1) ? $clog2(HALF) : 1;
	localparam int unsigned LC_RST    = (LEDCT_RST > MAX_LEDS) ? MAX_LEDS : LEDCT_RST;
	localparam int unsigned LATCH_RST = 3 * ((LC_RST + 63) / 64);

	// Architectural state.
	logic [LEDCT_W-1:0] led_count_q;
	logic               disp_sel_q;
	logic [2:0]         bit_pos_q;
	logic [IDX_W-1:0]   byte_idx_q;
	logic [LATCH_W-1:0] latch_cnt_q;
	logic               sending_latch_q;

	// Pipeline registers.
	logic       valid_s1;
	logic       pulse_s1;
	logic       latch_s1;
	logic       fend_s1;
	logic [2:0] bit_pos_s1;
	logic       valid_s2;
	logic       pulse_s2;
	logic       data_s2;
	logic       latch_s2;
	logic       fend_s2;

	mode_t                mode;
	logic [ADDR_W-1:0]    in_addr;
	logic [VALUE_W-1:0]   in_value;
	logic                 accept;
	logic                 s1_adv;
	logic                 is_tick;
	logic [LATCH_W-1:0]   latch_needed;
	logic [IDX_W-1:0]     rd_idx;
	logic [AW-1:0]        ram_waddr;
	logic [AW-1:0]        ram_raddr;
	logic                 ram_we;
	logic                 ram_re;
	logic [VALUE_W-1:0]   ram_rdata;
	logic                 pixel_last;
	logic [LEDCT_W-1:0]   cfg_clamped;
	logic [VALUE_W-1:0]   out_byte;

	assign mode     = mode_t'(s_tuser);
	assign in_addr  = s_tdata[ADDR_W-1:0];
	assign in_value = s_tdata[ADDR_W +: VALUE_W];

	// Handshake: the result register frees stage one, stage one frees the input.
	assign s1_adv    = !valid_s2 || m_tready;
	assign s_tready  = !valid_s1 || s1_adv;
	assign accept    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	assign is_tick   = accept && (mode == MODE_TICK);

	// Latch length for the current strip length: 3 * ceil(led_count / 64).
	always_comb begin
		logic [LEDCT_W:0] rounded;
		rounded      = ({1'b0, led_count_q} + (LEDCT_W + 1)'(63)) >> 6;
		latch_needed = LATCH_W'(rounded) + LATCH_W'({rounded, 1'b0});
	end

	// Frame RAM addressing: edit half for writes, display half for reads.
	assign rd_idx    = (32'(byte_idx_q) < HALF) ? byte_idx_q : '0;
	assign ram_raddr = (disp_sel_q ? AW'(HALF) : AW'(0)) + AW'(rd_idx);
	assign ram_waddr = (disp_sel_q ? AW'(0) : AW'(HALF)) + AW'(in_addr);
	assign ram_we    = accept && (mode == MODE_WRITE) && (32'(in_addr) < HALF);
	assign ram_re    = is_tick && !sending_latch_q;

	lsfs_ram #(
		.WIDTH (VALUE_W),
		.DEPTH (DEPTH)
	) u_frame_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (in_value),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Last pixel byte of the frame for the current strip length.
	assign pixel_last = (16'(byte_idx_q) + 16'd1) >= (16'(led_count_q) * 16'd3);

	// Out-of-range strip lengths are clamped to the supported span.
	always_comb begin
		cfg_clamped = cfg_data;
		if (cfg_data == '0) begin
			cfg_clamped = LEDCT_W'(1);
		end else if (32'(cfg_data) > MAX_LEDS) begin
			cfg_clamped = LEDCT_W'(MAX_LEDS);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			led_count_q <= LEDCT_W'(LC_RST);
		end else if (cfg_valid && cfg_ready) begin
			led_count_q <= cfg_clamped;
		end
	end

	// Serializer state advances as each beat is accepted.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			disp_sel_q      <= 1'b0;
			bit_pos_q       <= 3'd7;
			byte_idx_q      <= '0;
			latch_cnt_q     <= LATCH_W'(LATCH_RST);
			sending_latch_q <= 1'b1;
		end else if (accept) begin
			unique case (mode)
				MODE_SWAP: begin
					disp_sel_q <= !disp_sel_q;
				end
				MODE_TICK: begin
					if (bit_pos_q != 3'd0) begin
						bit_pos_q <= bit_pos_q - 3'd1;
					end else begin
						bit_pos_q <= 3'd7;
						if (sending_latch_q) begin
							if (latch_cnt_q <= LATCH_W'(1)) begin
								latch_cnt_q     <= '0;
								sending_latch_q <= 1'b0;
								byte_idx_q      <= '0;
							end else begin
								latch_cnt_q <= latch_cnt_q - LATCH_W'(1);
							end
						end else if (pixel_last) begin
							sending_latch_q <= 1'b1;
							latch_cnt_q     <= latch_needed;
							byte_idx_q      <= '0;
						end else begin
							byte_idx_q <= byte_idx_q + IDX_W'(1);
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Stage one control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// Stage one payload: what the tick needs once the RAM byte arrives.
	always_ff @(posedge clk) begin
		if (accept) begin
			pulse_s1   <= is_tick;
			latch_s1   <= is_tick && sending_latch_q;
			fend_s1    <= is_tick && sending_latch_q && (bit_pos_q == 3'd0)
				&& (latch_cnt_q <= LATCH_W'(1));
			bit_pos_s1 <= bit_pos_q;
		end
	end

	// Pick the serial bit out of the marked pixel byte.
	assign out_byte = PIXEL_MARK | ram_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s1_adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && valid_s1) begin
			pulse_s2 <= pulse_s1;
			data_s2  <= pulse_s1 && !latch_s1 && out_byte[bit_pos_s1];
			latch_s2 <= latch_s1;
			fend_s2  <= fend_s1;
		end
	end

	// Result beat.
	assign m_tvalid = valid_s2;
	assign m_tdata  = {(OUT_DW - 2)'(0), data_s2, pulse_s2};
	assign m_tuser  = latch_s2;
	assign m_tlast  = fend_s2;

endmodule

>>> verif/led_strip_frame_serializer_unit_tb.sv
`timescale 1ns / 1ps

module led_strip_frame_serializer_unit_tb;
	import lsfs_pkg::*;

	localparam int unsigned STRIP_MAX  = 512;
	localparam int unsigned HALF_BYTES = 3 * STRIP_MAX;
	localparam int unsigned PIPE_DELAY = 4;
	localparam int unsigned MAX_REPORTS = 10;
	// Pixel reads stay below this many LEDs, so only that part of each half is filled.
	localparam int unsigned FILL_LEDS  = 6;
	localparam int unsigned FILL_BYTES = 3 * FILL_LEDS;

	// One serial output beat as the strip sees it.
	typedef struct packed {
		logic pulse;
		logic level;
		logic latch;
		logic frame_end;
	} strip_bits_t;

	logic                clk;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [IN_DW-1:0]    s_tdata;   // [10:0] byte_address, [18:11] byte_value, zero pad
	logic [MODE_W-1:0]   s_tuser;   // [1:0] mode
	logic                m_tvalid;
	logic                m_tready;
	logic [OUT_DW-1:0]   m_tdata;   // [0] clock_pulse, [1] data_bit, zero pad
	logic [0:0]          m_tuser;   // [0] in_latch
	logic                m_tlast;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [LEDCT_W-1:0]  cfg_data;

	// Shadow copy of the serializer state.
	logic [VALUE_W-1:0]  frame_mem [0:2*HALF_BYTES-1];
	logic                shown_half = 1'b0;
	int unsigned         bit_pos = 7;
	int unsigned         byte_idx = 0;
	int unsigned         latch_left = 3 * ((LEDCT_RST + 63) / 64);
	logic                in_latch_phase = 1'b1;
	int unsigned         strip_leds = (LEDCT_RST > STRIP_MAX) ? STRIP_MAX : LEDCT_RST;
	int unsigned         frames_done = 0;

	strip_bits_t         expected_bits [$];
	int unsigned         error_count = 0;
	logic                bursty_idle = 1'b1;
	int unsigned         hold_off_cycles = 0;

	led_strip_frame_serializer_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	// Clock.
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Hard limit on the run time.
	initial begin
		#20_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	// Latch bytes for the current strip length.
	function automatic int unsigned latch_bytes_for_strip();
		return 3 * ((strip_leds + 63) / 64);
	endfunction

	// Advance the shadow serializer by one accepted beat and return its output.
	function automatic strip_bits_t serialize_step(input mode_t op,
			input logic [ADDR_W-1:0] addr, input logic [VALUE_W-1:0] val);
		strip_bits_t r;
		logic [VALUE_W-1:0] cur;
		int unsigned idx;
		r = '0;
		case (op)
			MODE_WRITE: begin
				if (addr < HALF_BYTES)
					frame_mem[(shown_half ^ 1'b1) * HALF_BYTES + addr] = val;
			end
			MODE_SWAP: begin
				shown_half = ~shown_half;
			end
			MODE_TICK: begin
				r.pulse = 1'b1;
				if (in_latch_phase) begin
					cur = '0;
					r.latch = 1'b1;
				end else begin
					idx = (byte_idx < HALF_BYTES) ? byte_idx : 0;
					cur = PIXEL_MARK | frame_mem[shown_half * HALF_BYTES + idx];
				end
				r.level = cur[bit_pos];
				if (bit_pos != 0) begin
					bit_pos--;
				end else begin
					bit_pos = 7;
					if (in_latch_phase) begin
						if (latch_left <= 1) begin
							r.frame_end = 1'b1;
							frames_done++;
							latch_left = 0;
							in_latch_phase = 1'b0;
							byte_idx = 0;
						end else begin
							latch_left--;
						end
					end else if (byte_idx + 1 >= 3 * strip_leds) begin
						in_latch_phase = 1'b1;
						latch_left = latch_bytes_for_strip();
						byte_idx = 0;
					end else begin
						byte_idx++;
					end
				end
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	// Offer one input beat, with an optional idle burst first.
	task automatic send_beat(input mode_t op, input logic [ADDR_W-1:0] addr,
			input logic [VALUE_W-1:0] val);
		@(negedge clk);
		if (bursty_idle && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {{(IN_DW - ADDR_W - VALUE_W){1'b0}}, val, addr};
		do @(posedge clk); while (!s_tready);
		expected_bits.push_back(serialize_step(op, addr, val));
	endtask

	// Stop offering beats and wait for every pending result.
	task automatic drain_results();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (expected_bits.size() != 0) @(posedge clk);
	endtask

	// Write led_count while the block is idle.
	task automatic set_strip_length(input logic [LEDCT_W-1:0] leds);
		drain_results();
		repeat (PIPE_DELAY) @(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= leds;
		do @(posedge clk); while (!cfg_ready);
		strip_leds = (leds < 1) ? 1 : (leds > STRIP_MAX) ? STRIP_MAX : leds;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Mostly ticks with writes, swaps and unused codes mixed in.
	task automatic send_random_item();
		int unsigned pick;
		logic [ADDR_W-1:0] addr;
		pick = $urandom_range(0, 99);
		addr = ($urandom_range(0, 2) == 0) ? ADDR_W'($urandom_range(0, 2047))
				: ADDR_W'($urandom_range(0, 3 * strip_leds - 1));
		if (pick < 65)
			send_beat(MODE_TICK, ADDR_W'($urandom_range(0, 2047)),
				VALUE_W'($urandom_range(0, 255)));
		else if (pick < 87)
			send_beat(MODE_WRITE, addr, VALUE_W'($urandom_range(0, 255)));
		else if (pick < 94)
			send_beat(MODE_SWAP, addr, VALUE_W'($urandom_range(0, 255)));
		else
			send_beat(MODE_NONE, addr, VALUE_W'($urandom_range(0, 255)));
	endtask

	// Tick until the shadow model has closed one more frame.
	task automatic tick_to_frame_end();
		int unsigned start;
		start = frames_done;
		while (frames_done == start)
			send_beat(MODE_TICK, '0, '0);
	endtask

	// Reset state: ignored items, then the opening latch bytes.
	task automatic test_reset_latch();
		send_beat(MODE_NONE, 11'h7FF, 8'hFF);
		send_beat(MODE_WRITE, 11'd1536, 8'hAA);
		send_beat(MODE_WRITE, 11'h7FF, 8'h55);
		tick_to_frame_end();
	endtask

	// Give every byte that a pixel read can reach in both halves a value.
	task automatic test_fill_frame_memory();
		for (int h = 0; h < 2; h++) begin
			for (int a = 0; a < FILL_BYTES; a++)
				send_beat(MODE_WRITE, ADDR_W'(a), VALUE_W'($urandom_range(0, 255)));
			send_beat(MODE_SWAP, '0, '0);
		end
	endtask

	// One-LED strip with extreme colour bytes and swaps in the middle of a byte.
	task automatic test_edge_bytes();
		set_strip_length('0);
		send_beat(MODE_WRITE, 11'd0, 8'h7F);
		send_beat(MODE_WRITE, 11'd1, 8'h00);
		send_beat(MODE_WRITE, 11'd2, 8'hFF);
		send_beat(MODE_SWAP, '0, '0);
		repeat (4) send_beat(MODE_TICK, '0, '0);
		send_beat(MODE_SWAP, '0, '0);
		repeat (3) send_beat(MODE_TICK, '0, '0);
		send_beat(MODE_SWAP, '0, '0);
		tick_to_frame_end();
		tick_to_frame_end();
	endtask

	// Several strip lengths, each changed partway through a frame.
	task automatic test_strip_lengths();
		int unsigned lengths [3] = '{2, 5, 3};
		foreach (lengths[i]) begin
			set_strip_length(LEDCT_W'(lengths[i]));
			repeat (40 + $urandom_range(0, 10))
				send_random_item();
		end
	endtask

	// Lengths above the supported span are clamped; a short strip then closes the frame.
	task automatic test_full_strip();
		set_strip_length(10'd1023);
		repeat (8) send_beat(MODE_TICK, '0, '0);
		set_strip_length(10'd513);
		repeat (8) send_beat(MODE_TICK, '0, '0);
		set_strip_length(10'd2);
		tick_to_frame_end();
	endtask

	// The receiver holds off while beats keep coming, so the block backs up.
	task automatic test_backpressure();
		set_strip_length(10'd1);
		hold_off_cycles = 300;
		repeat (30) send_beat(MODE_TICK, '0, '0);
	endtask

	// Random traffic over several strip lengths; the last chunk runs without idling.
	task automatic test_random_traffic();
		int unsigned lengths [3] = '{1, 4, 0};
		lengths[2] = $urandom_range(1, FILL_LEDS - 1);
		foreach (lengths[i]) begin
			set_strip_length(LEDCT_W'(lengths[i]));
			if (i == 2)
				bursty_idle = 1'b0;
			repeat (50) send_random_item();
		end
	endtask

	// Receiver ready with random stall bursts and the occasional long hold-off.
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_cycles > 0) begin
				m_tready <= 1'b0;
				repeat (hold_off_cycles) @(negedge clk);
				hold_off_cycles = 0;
				m_tready <= 1'b1;
			end else if (bursty_idle && $urandom_range(0, 5) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 3)) @(negedge clk);
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Compare each result beat with the oldest prediction.
	always @(posedge clk) begin : check_results
		strip_bits_t got;
		strip_bits_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = {m_tdata[0], m_tdata[1], m_tuser[0], m_tlast};
			if (expected_bits.size() == 0) begin
				error_count++;
				if (error_count <= MAX_REPORTS)
					$display("result beat with no prediction: pulse=%0b data=%0b latch=%0b end=%0b",
						got.pulse, got.level, got.latch, got.frame_end);
			end else begin
				want = expected_bits.pop_front();
				if (got !== want) begin
					error_count++;
					if (error_count <= MAX_REPORTS)
						$display("mismatch: expected pulse=%0b data=%0b latch=%0b end=%0b, %s",
							want.pulse, want.level, want.latch, want.frame_end,
							$sformatf("got pulse=%0b data=%0b latch=%0b end=%0b",
								got.pulse, got.level, got.latch, got.frame_end));
				end
			end
		end
	end

	// Reset, run each test in turn, then give the verdict.
	initial begin
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = MODE_WRITE;
		cfg_valid = 1'b0;
		cfg_data  = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_latch();
		test_fill_frame_memory();
		test_edge_bytes();
		test_strip_lengths();
		test_full_strip();
		test_backpressure();
		test_random_traffic();

		drain_results();
		repeat (10) @(posedge clk);
		if (error_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
